[rtl/sd_card_spi_host_sequencer_macros.svh]
// Assertion macros for the SD card SPI host sequencer
`ifndef SD_CARD_SPI_HOST_SEQUENCER_MACROS_SVH
`define SD_CARD_SPI_HOST_SEQUENCER_MACROS_SVH
`ifndef SYNTH
`define SDH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SDH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SDH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SDH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/sdh_pkg.sv]
// Types and constants shared by the SD card SPI host sequencer
package sdh_pkg;
  localparam logic [1:0] FUNC_INIT  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_XFER  = 2'd3;

  localparam logic [1:0] CFG_IDLE_RETRY = 2'd0;
  localparam logic [1:0] CFG_INIT_RETRY = 2'd1;
  localparam logic [1:0] CFG_RESP_WAIT  = 2'd2;
  localparam logic [1:0] CFG_DATA_WAIT  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_IDLE   = 3'd1;
  localparam logic [2:0] ST_INIT_TO   = 3'd2;
  localparam logic [2:0] ST_CMD_REJ   = 3'd3;
  localparam logic [2:0] ST_TOKEN_TO  = 3'd4;
  localparam logic [2:0] ST_WR_REJ    = 3'd5;
  localparam logic [2:0] ST_BUSY_TO   = 3'd6;

  localparam logic [1:0] CT_UNKNOWN = 2'd0;
  localparam logic [1:0] CT_V1      = 2'd1;
  localparam logic [1:0] CT_HC      = 2'd2;
  localparam logic [1:0] CT_V2SC    = 2'd3;

  localparam logic [5:0] CMD_GO_IDLE = 6'd0;
  localparam logic [5:0] CMD_IF_COND = 6'd8;
  localparam logic [5:0] CMD_READ1   = 6'd17;
  localparam logic [5:0] CMD_WRITE1  = 6'd24;
  localparam logic [5:0] CMD_OP_COND = 6'd41;
  localparam logic [5:0] CMD_APP     = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [7:0]  CMD_START   = 8'h40;
  localparam logic [7:0]  CRC_IF_COND = 8'h87;
  localparam logic [7:0]  CRC_DEFAULT = 8'h95;
  localparam logic [7:0]  TOKEN_START = 8'hFE;
  localparam logic [7:0]  DRESP_MASK  = 8'h1F;
  localparam logic [7:0]  DRESP_OK    = 8'h05;
  localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
  localparam int          ADDR_SHIFT  = 9;

  // one-hot phase codes
  typedef enum logic [16:0] {
    PH_IDLE  = 17'h00001, PH_DUMMY = 17'h00002, PH_CSEND = 17'h00004,
    PH_CRESP = 17'h00008, PH_COCR  = 17'h00010, PH_CTAIL = 17'h00020,
    PH_GAP0  = 17'h00040, PH_RTOK  = 17'h00080, PH_RDAT  = 17'h00100,
    PH_RCRC  = 17'h00200, PH_WTOK  = 17'h00400, PH_WDAT  = 17'h00800,
    PH_WCRC  = 17'h01000, PH_WRESP = 17'h02000, PH_BUSY1 = 17'h04000,
    PH_WGAP  = 17'h08000, PH_BUSY2 = 17'h10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] block_addr;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_data;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cs_active;
    logic        rd_valid;
    logic [7:0]  rd_data;
    logic        wr_need;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  card_response;
    logic [1:0]  card_type;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  idle_retry_limit;
    logic [7:0]  init_retry_limit;
    logic [7:0]  response_wait_limit;
    logic [15:0] data_wait_limit;
  } cfg_regs_t;
endpackage

[rtl/sdh_core.sv]
// Sequencer state machine: one SPI byte exchange per request
module sdh_core #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  sdh_pkg::in_item_t item,
  input  sdh_pkg::cfg_regs_t cfg,
  output sdh_pkg::out_item_t res,
  output logic              busy
);
  import sdh_pkg::*;

  localparam int BW = $clog2(BLOCK_BYTES + 1);

  phase_t      phase_r, phase_nxt;
  logic [BW-1:0] byte_count_r, byte_count_nxt;
  logic [15:0] wait_count_r, wait_count_nxt;
  logic [7:0]  attempt_r, attempt_nxt;
  logic [2:0]  frame_idx_r, frame_idx_nxt;
  logic [31:0] frame_arg_r, frame_arg_nxt;
  logic [7:0]  last_r1_r, last_r1_nxt;
  logic        hc_r, hc_nxt, v2_r, v2_nxt;
  logic [1:0]  card_kind_r, card_kind_nxt;
  logic [5:0]  cur_cmd_r, cur_cmd_nxt;
  logic [7:0]  rx;
  logic [7:0]  att_inc;
  logic        wait_exp;
  logic [BW-1:0] bc_inc;

  assign busy = (phase_r != PH_IDLE);
  assign rx = item.rx_byte;
  assign att_inc = attempt_r + 8'd1;
  assign bc_inc = byte_count_r + BW'(1);
  assign wait_exp = ({1'b0, wait_count_r} > {1'b0, cfg.data_wait_limit})
                    || (wait_count_r == 16'hFFFF);

  // frame byte for a given index of the current command
  function automatic logic [7:0] frame_byte(input logic [5:0] cmd, input logic [31:0] arg,
                                            input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = {2'b00, cmd} | CMD_START;
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: b = (cmd == CMD_IF_COND) ? CRC_IF_COND : CRC_DEFAULT;
    endcase
    return b;
  endfunction

  always_comb begin
    logic       do_send;
    logic [5:0] s_cmd;
    logic [31:0] s_arg;
    phase_nxt = phase_r; byte_count_nxt = byte_count_r; wait_count_nxt = wait_count_r;
    attempt_nxt = attempt_r; frame_idx_nxt = frame_idx_r; frame_arg_nxt = frame_arg_r;
    last_r1_nxt = last_r1_r; hc_nxt = hc_r; v2_nxt = v2_r; card_kind_nxt = card_kind_r;
    cur_cmd_nxt = cur_cmd_r;
    res = '0;
    do_send = 1'b0; s_cmd = CMD_GO_IDLE; s_arg = '0;

    if (item.func != FUNC_XFER) begin
      if (phase_r == PH_IDLE) begin
        if (item.func == FUNC_INIT) begin
          phase_nxt = PH_DUMMY; byte_count_nxt = '0;
          res.tx_valid = 1'b1; res.tx_byte = IDLE_BYTE;
        end else begin
          do_send = 1'b1;
          s_cmd = (item.func == FUNC_READ) ? CMD_READ1 : CMD_WRITE1;
          s_arg = item.block_addr;
        end
      end
    end else begin
      unique case (phase_r)
        PH_DUMMY: begin
          byte_count_nxt = bc_inc;
          if (bc_inc < BW'(10)) begin
            res.tx_valid = 1'b1; res.tx_byte = IDLE_BYTE;
          end else begin
            attempt_nxt = '0; do_send = 1'b1; s_cmd = CMD_GO_IDLE;
          end
        end
        PH_CSEND: begin
          frame_idx_nxt = frame_idx_r + 3'd1;
          res.tx_valid = 1'b1; res.cs_active = 1'b1;
          if (frame_idx_r < 3'd5) begin
            res.tx_byte = frame_byte(cur_cmd_r, frame_arg_r, frame_idx_r + 3'd1);
          end else begin
            phase_nxt = PH_CRESP; wait_count_nxt = '0; res.tx_byte = IDLE_BYTE;
          end
        end
        PH_CRESP: begin
          res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
          if (rx == IDLE_BYTE && wait_count_r <= {8'd0, cfg.response_wait_limit}) begin
            wait_count_nxt = wait_count_r + 16'd1;
          end else begin
            last_r1_nxt = rx;
            if (rx == 8'd0 && cur_cmd_r == CMD_READ_OCR) begin
              phase_nxt = PH_COCR; byte_count_nxt = '0;
            end else begin
              phase_nxt = PH_CTAIL;
            end
          end
        end
        PH_COCR: begin
          if (byte_count_r == '0) hc_nxt = rx[6];
          byte_count_nxt = bc_inc;
          if (bc_inc >= BW'(4)) phase_nxt = PH_CTAIL;
          res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
        end
        PH_CTAIL: begin
          priority case (cur_cmd_r)
            CMD_GO_IDLE: begin
              attempt_nxt = att_inc;
              if (att_inc > cfg.idle_retry_limit || att_inc == 8'd0) begin
                phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_NO_IDLE;
              end else if (last_r1_r == 8'd1) begin
                phase_nxt = PH_GAP0; byte_count_nxt = '0;
                res.tx_valid = 1'b1; res.tx_byte = IDLE_BYTE;
              end else begin
                do_send = 1'b1; s_cmd = CMD_GO_IDLE;
              end
            end
            CMD_IF_COND: begin
              attempt_nxt = att_inc;
              if (att_inc > cfg.init_retry_limit || att_inc == 8'd0) begin
                v2_nxt = 1'b0; card_kind_nxt = CT_V1; attempt_nxt = '0;
                do_send = 1'b1; s_cmd = CMD_APP;
              end else if (last_r1_r == 8'd1) begin
                attempt_nxt = '0; do_send = 1'b1; s_cmd = CMD_APP;
              end else begin
                do_send = 1'b1; s_cmd = CMD_IF_COND; s_arg = ARG_IF_COND;
              end
            end
            CMD_APP: begin
              do_send = 1'b1; s_cmd = CMD_OP_COND; s_arg = ARG_HCS;
            end
            CMD_OP_COND: begin
              attempt_nxt = att_inc;
              if (att_inc > cfg.init_retry_limit || att_inc == 8'd0) begin
                phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_INIT_TO;
              end else if (last_r1_r == 8'd0) begin
                hc_nxt = 1'b0;
                if (v2_r) begin
                  attempt_nxt = '0; do_send = 1'b1; s_cmd = CMD_READ_OCR;
                end else begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1;
                end
              end else begin
                do_send = 1'b1; s_cmd = CMD_APP;
              end
            end
            CMD_READ_OCR: begin
              attempt_nxt = att_inc;
              if (att_inc > cfg.init_retry_limit || att_inc == 8'd0) begin
                card_kind_nxt = CT_UNKNOWN; phase_nxt = PH_IDLE; res.done_res = 1'b1;
              end else if (last_r1_r == 8'd0) begin
                card_kind_nxt = hc_r ? CT_HC : CT_V2SC;
                phase_nxt = PH_IDLE; res.done_res = 1'b1;
              end else begin
                do_send = 1'b1; s_cmd = CMD_READ_OCR;
              end
            end
            CMD_READ1: begin
              if (last_r1_r != 8'd0) begin
                phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_CMD_REJ;
                res.card_response = last_r1_r;
              end else begin
                phase_nxt = PH_RTOK; wait_count_nxt = '0;
                res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
              end
            end
            default: begin
              if (last_r1_r != 8'd0) begin
                phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_CMD_REJ;
                res.card_response = last_r1_r;
              end else begin
                phase_nxt = PH_WTOK;
                res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = TOKEN_START;
                res.wr_need = 1'b1;
              end
            end
          endcase
        end
        PH_GAP0: begin
          byte_count_nxt = bc_inc;
          if (bc_inc < BW'(2)) begin
            res.tx_valid = 1'b1; res.tx_byte = IDLE_BYTE;
          end else begin
            attempt_nxt = '0; v2_nxt = 1'b1;
            do_send = 1'b1; s_cmd = CMD_IF_COND; s_arg = ARG_IF_COND;
          end
        end
        PH_RTOK: begin
          if (rx == TOKEN_START) begin
            phase_nxt = PH_RDAT; byte_count_nxt = '0;
            res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
          end else if (wait_exp) begin
            phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_TOKEN_TO;
          end else begin
            wait_count_nxt = wait_count_r + 16'd1;
            res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
          end
        end
        PH_RDAT: begin
          res.rd_valid = 1'b1; res.rd_data = rx;
          byte_count_nxt = bc_inc;
          if (bc_inc >= BW'(BLOCK_BYTES)) begin
            phase_nxt = PH_RCRC; byte_count_nxt = '0;
          end
          res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
        end
        PH_RCRC: begin
          byte_count_nxt = bc_inc;
          if (bc_inc < BW'(3)) begin
            res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
          end else begin
            phase_nxt = PH_IDLE; res.done_res = 1'b1;
          end
        end
        PH_WTOK: begin
          phase_nxt = PH_WDAT; byte_count_nxt = '0;
          res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = item.wr_data;
          res.wr_need = (BLOCK_BYTES > 1);
        end
        PH_WDAT: begin
          byte_count_nxt = bc_inc;
          res.tx_valid = 1'b1; res.cs_active = 1'b1;
          if (bc_inc < BW'(BLOCK_BYTES)) begin
            res.tx_byte = item.wr_data;
            res.wr_need = (bc_inc < BW'(BLOCK_BYTES - 1));
          end else begin
            phase_nxt = PH_WCRC; byte_count_nxt = '0; res.tx_byte = IDLE_BYTE;
          end
        end
        PH_WCRC: begin
          byte_count_nxt = bc_inc;
          if (bc_inc >= BW'(2)) phase_nxt = PH_WRESP;
          res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
        end
        PH_WRESP: begin
          if ((rx & DRESP_MASK) != DRESP_OK) begin
            phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_WR_REJ;
            res.card_response = rx;
          end else begin
            phase_nxt = PH_BUSY1; wait_count_nxt = '0;
            res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
          end
        end
        PH_BUSY1, PH_BUSY2: begin
          if (rx != 8'd0) begin
            if (phase_r == PH_BUSY1) begin
              phase_nxt = PH_WGAP; res.tx_valid = 1'b1; res.tx_byte = IDLE_BYTE;
            end else begin
              phase_nxt = PH_IDLE; res.done_res = 1'b1;
            end
          end else if (wait_exp) begin
            phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_BUSY_TO;
          end else begin
            wait_count_nxt = wait_count_r + 16'd1;
            res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
          end
        end
        PH_WGAP: begin
          phase_nxt = PH_BUSY2;
          res.tx_valid = 1'b1; res.cs_active = 1'b1; res.tx_byte = IDLE_BYTE;
        end
        default: ;
      endcase
    end

    // start a command frame
    if (do_send) begin
      cur_cmd_nxt = s_cmd;
      frame_arg_nxt = (!hc_nxt && (s_cmd == CMD_READ1 || s_cmd == CMD_WRITE1))
                      ? (s_arg << ADDR_SHIFT) : s_arg;
      phase_nxt = PH_CSEND; frame_idx_nxt = '0;
      res.tx_valid = 1'b1; res.cs_active = 1'b1;
      res.tx_byte = {2'b00, s_cmd} | CMD_START;
    end
    res.card_type = card_kind_nxt;
  end

  // advance state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; byte_count_r <= '0; wait_count_r <= '0; attempt_r <= '0;
      frame_idx_r <= '0; frame_arg_r <= '0; last_r1_r <= 8'hFF; hc_r <= 1'b0;
      v2_r <= 1'b1; card_kind_r <= CT_UNKNOWN; cur_cmd_r <= CMD_GO_IDLE;
    end else if (step) begin
      phase_r <= phase_nxt; byte_count_r <= byte_count_nxt; wait_count_r <= wait_count_nxt;
      attempt_r <= attempt_nxt; frame_idx_r <= frame_idx_nxt; frame_arg_r <= frame_arg_nxt;
      last_r1_r <= last_r1_nxt; hc_r <= hc_nxt; v2_r <= v2_nxt;
      card_kind_r <= card_kind_nxt; cur_cmd_r <= cur_cmd_nxt;
    end
  end
endmodule

[rtl/sd_card_spi_host_sequencer.sv]
// Result: a request's result is registered and offered in the cycle after acceptance.
// Throughput: one request per cycle; the output register is refilled while it
// is drained, so in_ready follows only whether the result slot can be freed.
// Reset: synchronous active-low rst_n returns the sequencer to idle, config
// registers to their defaults and empties the result register.
// Top level: config registers, request/result handshake, sequencer core.
`include "sd_card_spi_host_sequencer_macros.svh"
module sd_card_spi_host_sequencer #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sdh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sdh_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import sdh_pkg::*;

  cfg_regs_t  cfg_r;
  out_item_t  res;
  out_item_t  out_data_r;
  logic       out_valid_r;
  logic       step;
  logic       core_busy;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_retry_limit    <= 8'd32;
      cfg_r.init_retry_limit    <= 8'd254;
      cfg_r.response_wait_limit <= 8'd254;
      cfg_r.data_wait_limit     <= 16'd65534;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_RETRY: cfg_r.idle_retry_limit    <= cfg_wdata[7:0];
        CFG_INIT_RETRY: cfg_r.init_retry_limit    <= cfg_wdata[7:0];
        CFG_RESP_WAIT:  cfg_r.response_wait_limit <= cfg_wdata[7:0];
        default:        cfg_r.data_wait_limit     <= cfg_wdata;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign step = in_valid && in_ready;

  sdh_core #(.BLOCK_BYTES(BLOCK_BYTES)) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .item(in_data), .cfg(cfg_r),
    .res(res), .busy(core_busy)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  `SDH_ASSERT_NEXT(a_step_fills, clk, rst_n, step, out_valid, "accepted request left no result")
  `SDH_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result lost")
  `SDH_ASSERT_IMPL(a_done_idle, clk, rst_n, step && res.done_res, !res.tx_valid, "done result starts an exchange")
  `SDH_ASSERT_NEXT(a_done_to_idle, clk, rst_n, step && res.done_res, !core_busy, "sequencer not idle after done")
endmodule
